/* rtl/assert_macros.svh */
// assertion macros shared by the checker files
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge, reset included
`define CSOT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only while out of reset
`define CSOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/csot_pkg.sv */
// shared types and constants for the cylinder / sphere overlap test
// no dependencies
`timescale 1ns / 1ps

package csot_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        KIND_ORDINARY = 2'd0,
        KIND_INTERNAL = 2'd1,
        KIND_EXTERNAL = 2'd2
    } kind_t;

    // per-pair decisions that ride along with the arithmetic
    typedef struct packed {
        logic ring;     // internal / external boundary pair
        logic rin_le;   // inner radius not above outer radius
        logic a_cyl;    // first body has height
        logic b_cyl;    // second body has height
        logic span_ok;  // vertical rule met, valid from the square stage on
    } ctrl_t;

endpackage

/* rtl/csot_prep.sv */
// stage 1: kind decode, coordinate differences and vertical span ends
// depends on csot_pkg
`timescale 1ns / 1ps

module csot_prep
    import csot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [1:0]                    a_kind,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic [COORD_WIDTH-2:0]        a_radius,
    input  logic [COORD_WIDTH-2:0]        a_height,
    input  logic [1:0]                    b_kind,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic [COORD_WIDTH-2:0]        b_radius,
    input  logic [COORD_WIDTH-2:0]        b_height,
    output logic                          out_valid,
    output ctrl_t                         ctrl,
    output logic signed [COORD_WIDTH:0]   dx,
    output logic signed [COORD_WIDTH:0]   dy,
    output logic signed [COORD_WIDTH:0]   dz,
    output logic [COORD_WIDTH-1:0]        rs,
    output logic [COORD_WIDTH-2:0]        rd,
    output logic signed [COORD_WIDTH:0]   ya0,
    output logic signed [COORD_WIDTH:0]   ya1,
    output logic signed [COORD_WIDTH:0]   ya_lo,
    output logic signed [COORD_WIDTH:0]   ya_hi,
    output logic signed [COORD_WIDTH:0]   yb0,
    output logic signed [COORD_WIDTH:0]   yb1,
    output logic signed [COORD_WIDTH:0]   yb_lo,
    output logic signed [COORD_WIDTH:0]   yb_hi
);

    localparam int W = COORD_WIDTH;

    logic                 valid_reg;
    ctrl_t                ctrl_reg, ctrl_next;
    logic signed [W:0]    dx_reg, dy_reg, dz_reg;
    logic signed [W:0]    dx_next, dy_next, dz_next;
    logic [W-1:0]         rs_reg, rs_next;
    logic [W-2:0]         rd_reg, rd_next;
    logic signed [W:0]    ya0_reg, ya1_reg, ya_lo_reg, ya_hi_reg;
    logic signed [W:0]    yb0_reg, yb1_reg, yb_lo_reg, yb_hi_reg;
    logic signed [W:0]    ya0_next, ya1_next, ya_lo_next, ya_hi_next;
    logic signed [W:0]    yb0_next, yb1_next, yb_lo_next, yb_hi_next;
    logic signed [W:0]    ar_s, ah_s, br_s, bh_s;
    logic [W-2:0]         rin, rext;
    logic                 a_int;

    always_comb
    begin
        a_int = (a_kind == KIND_INTERNAL);
        ctrl_next.ring = (a_int && (b_kind == KIND_EXTERNAL)) ||
                         ((a_kind == KIND_EXTERNAL) && (b_kind == KIND_INTERNAL));
        rin  = a_int ? a_radius : b_radius;
        rext = a_int ? b_radius : a_radius;
        ctrl_next.rin_le  = (rin <= rext);
        ctrl_next.a_cyl   = (a_height != '0);
        ctrl_next.b_cyl   = (b_height != '0);
        ctrl_next.span_ok = 1'b0;
        // only meaningful when rin is above rext
        rd_next = rin - rext;
        rs_next = {1'b0, a_radius} + {1'b0, b_radius};

        ar_s = $signed({2'b00, a_radius});
        ah_s = $signed({2'b00, a_height});
        br_s = $signed({2'b00, b_radius});
        bh_s = $signed({2'b00, b_height});

        dx_next = $signed({a_x[W-1], a_x}) - $signed({b_x[W-1], b_x});
        dy_next = $signed({a_y[W-1], a_y}) - $signed({b_y[W-1], b_y});
        dz_next = $signed({a_z[W-1], a_z}) - $signed({b_z[W-1], b_z});

        ya0_next   = $signed({a_y[W-1], a_y});
        ya1_next   = ya0_next + ah_s;
        ya_lo_next = ya0_next - ar_s;
        ya_hi_next = ya0_next + ar_s;
        yb0_next   = $signed({b_y[W-1], b_y});
        yb1_next   = yb0_next + bh_s;
        yb_lo_next = yb0_next - br_s;
        yb_hi_next = yb0_next + br_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg  <= ctrl_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dz_reg    <= dz_next;
            rs_reg    <= rs_next;
            rd_reg    <= rd_next;
            ya0_reg   <= ya0_next;
            ya1_reg   <= ya1_next;
            ya_lo_reg <= ya_lo_next;
            ya_hi_reg <= ya_hi_next;
            yb0_reg   <= yb0_next;
            yb1_reg   <= yb1_next;
            yb_lo_reg <= yb_lo_next;
            yb_hi_reg <= yb_hi_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctrl      = ctrl_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign dz        = dz_reg;
    assign rs        = rs_reg;
    assign rd        = rd_reg;
    assign ya0       = ya0_reg;
    assign ya1       = ya1_reg;
    assign ya_lo     = ya_lo_reg;
    assign ya_hi     = ya_hi_reg;
    assign yb0       = yb0_reg;
    assign yb1       = yb1_reg;
    assign yb_lo     = yb_lo_reg;
    assign yb_hi     = yb_hi_reg;

endmodule

/* rtl/csot_square.sv */
// stage 2: squares of the differences and radii, vertical span rule
// depends on csot_pkg
`timescale 1ns / 1ps

module csot_square
    import csot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  ctrl_t                         in_ctrl,
    input  logic signed [COORD_WIDTH:0]   dx,
    input  logic signed [COORD_WIDTH:0]   dy,
    input  logic signed [COORD_WIDTH:0]   dz,
    input  logic [COORD_WIDTH-1:0]        rs,
    input  logic [COORD_WIDTH-2:0]        rd,
    input  logic signed [COORD_WIDTH:0]   ya0,
    input  logic signed [COORD_WIDTH:0]   ya1,
    input  logic signed [COORD_WIDTH:0]   ya_lo,
    input  logic signed [COORD_WIDTH:0]   ya_hi,
    input  logic signed [COORD_WIDTH:0]   yb0,
    input  logic signed [COORD_WIDTH:0]   yb1,
    input  logic signed [COORD_WIDTH:0]   yb_lo,
    input  logic signed [COORD_WIDTH:0]   yb_hi,
    output logic                          out_valid,
    output ctrl_t                         ctrl,
    output logic [2*COORD_WIDTH:0]        dx2,
    output logic [2*COORD_WIDTH:0]        dy2,
    output logic [2*COORD_WIDTH:0]        dz2,
    output logic [2*COORD_WIDTH-1:0]      rs2,
    output logic [2*COORD_WIDTH-3:0]      rd2
);

    localparam int W = COORD_WIDTH;

    logic                    valid_reg;
    ctrl_t                   ctrl_reg, ctrl_next;
    logic signed [2*W+1:0]   px, py, pz;
    logic [2*W:0]            dx2_reg, dy2_reg, dz2_reg;
    logic [2*W-1:0]          rs2_reg, rs2_next;
    logic [2*W-3:0]          rd2_reg, rd2_next;
    logic                    span_cs, span_sc, span_cc, span_ring;

    always_comb
    begin
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
        rs2_next = rs * rs;
        rd2_next = rd * rd;

        span_cs   = (ya0 <= yb_hi) && (ya1 >= yb_lo);
        span_sc   = (ya_lo <= yb1) && (ya_hi >= yb0);
        // two cylinders that only touch do not hit
        span_cc   = (ya0 < yb1) && (ya1 > yb0);
        span_ring = (ya0 <= yb1) && (ya1 >= yb0);

        ctrl_next = in_ctrl;
        if (in_ctrl.ring)
        begin
            ctrl_next.span_ok = span_ring;
        end
        else if (in_ctrl.a_cyl && !in_ctrl.b_cyl)
        begin
            ctrl_next.span_ok = span_cs;
        end
        else if (!in_ctrl.a_cyl && in_ctrl.b_cyl)
        begin
            ctrl_next.span_ok = span_sc;
        end
        else
        begin
            ctrl_next.span_ok = span_cc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= ctrl_next;
            dx2_reg  <= px[2*W:0];
            dy2_reg  <= py[2*W:0];
            dz2_reg  <= pz[2*W:0];
            rs2_reg  <= rs2_next;
            rd2_reg  <= rd2_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctrl      = ctrl_reg;
    assign dx2       = dx2_reg;
    assign dy2       = dy2_reg;
    assign dz2       = dz2_reg;
    assign rs2       = rs2_reg;
    assign rd2       = rd2_reg;

endmodule

/* rtl/csot_sum.sv */
// stage 3: horizontal and full distance sums
// depends on csot_pkg
`timescale 1ns / 1ps

module csot_sum
    import csot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  ctrl_t                         in_ctrl,
    input  logic [2*COORD_WIDTH:0]        dx2,
    input  logic [2*COORD_WIDTH:0]        dy2,
    input  logic [2*COORD_WIDTH:0]        dz2,
    input  logic [2*COORD_WIDTH-1:0]      in_rs2,
    input  logic [2*COORD_WIDTH-3:0]      in_rd2,
    output logic                          out_valid,
    output ctrl_t                         ctrl,
    output logic [2*COORD_WIDTH+1:0]      d2,
    output logic [2*COORD_WIDTH+1:0]      d3,
    output logic [2*COORD_WIDTH-1:0]      rs2,
    output logic [2*COORD_WIDTH-3:0]      rd2
);

    localparam int W = COORD_WIDTH;

    logic               valid_reg;
    ctrl_t              ctrl_reg;
    logic [2*W+1:0]     d2_reg, d2_next;
    logic [2*W+1:0]     d3_reg, d3_next;
    logic [2*W-1:0]     rs2_reg;
    logic [2*W-3:0]     rd2_reg;

    always_comb
    begin
        d2_next = {1'b0, dx2} + {1'b0, dz2};
        // three squares still fit, each is at most 2^(2W)
        d3_next = {1'b0, dx2} + {1'b0, dz2} + {1'b0, dy2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= in_ctrl;
            d2_reg   <= d2_next;
            d3_reg   <= d3_next;
            rs2_reg  <= in_rs2;
            rd2_reg  <= in_rd2;
        end
    end

    assign out_valid = valid_reg;
    assign ctrl      = ctrl_reg;
    assign d2        = d2_reg;
    assign d3        = d3_reg;
    assign rs2       = rs2_reg;
    assign rd2       = rd2_reg;

endmodule

/* rtl/csot_decide.sv */
// stage 4: distance compares and final hit, doubles as the output register
// depends on csot_pkg
`timescale 1ns / 1ps

module csot_decide
    import csot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  ctrl_t                         in_ctrl,
    input  logic [2*COORD_WIDTH+1:0]      d2,
    input  logic [2*COORD_WIDTH+1:0]      d3,
    input  logic [2*COORD_WIDTH-1:0]      rs2,
    input  logic [2*COORD_WIDTH-3:0]      rd2,
    output logic                          out_valid,
    output logic                          hit
);

    localparam int W = COORD_WIDTH;

    logic           valid_reg;
    logic           hit_reg, hit_next;
    logic [2*W+1:0] rs2_ext, rd2_ext;
    logic           near, ring_ok;

    always_comb
    begin
        rs2_ext = {2'b00, rs2};
        rd2_ext = {4'b0000, rd2};
        near    = (d2 <= rs2_ext);
        ring_ok = in_ctrl.rin_le || (rd2_ext <= d2);
        if (in_ctrl.ring)
        begin
            hit_next = ring_ok && in_ctrl.span_ok;
        end
        else if (!in_ctrl.a_cyl && !in_ctrl.b_cyl)
        begin
            hit_next = near && (d3 <= rs2_ext);
        end
        else
        begin
            hit_next = near && in_ctrl.span_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;

endmodule

/* rtl/cylinder_sphere_overlap_test_core.sv */
// cylinder / sphere overlap test, four register stages, one pair per clock when not stalled
// an accepted word passes the prep, square, sum and decide registers to the result word
// throughput: one word per cycle if not stalled; squaring multipliers set the clock
// a stalled result holds the pipe only as far back as it has to, bubbles close up
// reset: asynchronous, active low, clears every stage valid bit
`timescale 1ns / 1ps

module cylinder_sphere_overlap_test_core
    import csot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          stall,
    input  logic [1:0]                    a_kind,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic [COORD_WIDTH-2:0]        a_radius,
    input  logic [COORD_WIDTH-2:0]        a_height,
    input  logic [1:0]                    b_kind,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic [COORD_WIDTH-2:0]        b_radius,
    input  logic [COORD_WIDTH-2:0]        b_height,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          hit
);

    localparam int W = COORD_WIDTH;

    logic               en1, en2, en3, en4;
    logic               v1, v2, v3;
    ctrl_t              c1, c2, c3;
    logic signed [W:0]  dx, dy, dz;
    logic [W-1:0]       rs;
    logic [W-2:0]       rd;
    logic signed [W:0]  ya0, ya1, ya_lo, ya_hi, yb0, yb1, yb_lo, yb_hi;
    logic [2*W:0]       dx2, dy2, dz2;
    logic [2*W-1:0]     rs2_s2, rs2_s3;
    logic [2*W-3:0]     rd2_s2, rd2_s3;
    logic [2*W+1:0]     d2, d3;

    // a stage moves when it is empty or the one after it moves
    assign en4   = !res_valid || !res_stall;
    assign en3   = !v3 || en4;
    assign en2   = !v2 || en3;
    assign en1   = !v1 || en2;
    assign stall = !en1;

    csot_prep #(.COORD_WIDTH(W)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en1),
        .in_valid (valid),
        .a_kind   (a_kind),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_z      (a_z),
        .a_radius (a_radius),
        .a_height (a_height),
        .b_kind   (b_kind),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_z      (b_z),
        .b_radius (b_radius),
        .b_height (b_height),
        .out_valid(v1),
        .ctrl     (c1),
        .dx       (dx),
        .dy       (dy),
        .dz       (dz),
        .rs       (rs),
        .rd       (rd),
        .ya0      (ya0),
        .ya1      (ya1),
        .ya_lo    (ya_lo),
        .ya_hi    (ya_hi),
        .yb0      (yb0),
        .yb1      (yb1),
        .yb_lo    (yb_lo),
        .yb_hi    (yb_hi)
    );

    csot_square #(.COORD_WIDTH(W)) u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en2),
        .in_valid (v1),
        .in_ctrl  (c1),
        .dx       (dx),
        .dy       (dy),
        .dz       (dz),
        .rs       (rs),
        .rd       (rd),
        .ya0      (ya0),
        .ya1      (ya1),
        .ya_lo    (ya_lo),
        .ya_hi    (ya_hi),
        .yb0      (yb0),
        .yb1      (yb1),
        .yb_lo    (yb_lo),
        .yb_hi    (yb_hi),
        .out_valid(v2),
        .ctrl     (c2),
        .dx2      (dx2),
        .dy2      (dy2),
        .dz2      (dz2),
        .rs2      (rs2_s2),
        .rd2      (rd2_s2)
    );

    csot_sum #(.COORD_WIDTH(W)) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en3),
        .in_valid (v2),
        .in_ctrl  (c2),
        .dx2      (dx2),
        .dy2      (dy2),
        .dz2      (dz2),
        .in_rs2   (rs2_s2),
        .in_rd2   (rd2_s2),
        .out_valid(v3),
        .ctrl     (c3),
        .d2       (d2),
        .d3       (d3),
        .rs2      (rs2_s3),
        .rd2      (rd2_s3)
    );

    csot_decide #(.COORD_WIDTH(W)) u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en4),
        .in_valid (v3),
        .in_ctrl  (c3),
        .d2       (d2),
        .d3       (d3),
        .rs2      (rs2_s3),
        .rd2      (rd2_s3),
        .out_valid(res_valid),
        .hit      (hit)
    );

endmodule

/* rtl/csot_checker.sv */
// port-level checks for the overlap test core, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csot_props
(
    input logic clk,
    input logic rst_n,
    input logic valid,
    input logic stall,
    input logic res_valid,
    input logic res_stall,
    input logic hit
);

    // result side is empty while reset is held
    `CSOT_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !res_valid, "result word during reset")

    // a held result word keeps its value
    `CSOT_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(hit), "held result word changed")

    // input side only backs up when the result side is blocked
    `CSOT_ASSERT(a_stall_cause, stall |-> res_valid && res_stall, "input stalled without result backpressure")

    // an accepted word comes out as a result word when the result side does not stall
    `CSOT_ASSERT(a_latency, valid && !stall ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid, "result word missing after pipeline latency")

endmodule

bind cylinder_sphere_overlap_test_core csot_props u_csot_props (.*);
